// ----- design/assert_macros.svh -----
// assertion macros used by the wind rose histogram back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge, disabled while reset is held
`define WRH_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every rising edge, also during reset
`define WRH_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/wrh_pkg.sv -----
// shared types and constants of the wind rose histogram
package wrh_pkg;

  // field widths of the stream payload
  localparam int CLS_W       = 3;
  localparam int SEC_W       = 4;
  localparam int SPEED_W     = 16;
  localparam int DIR_W       = 13;
  localparam int OUT_COUNT_W = 32;
  localparam int LIMIT_W     = 15;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 40;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_LIMITS = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET [NUM_LIMITS] = '{
    15'd16, 15'd48, 15'd80, 15'd112, 15'd144
  };

  // parameter defaults
  localparam int DEF_SPEED_CLASSES = 6;
  localparam int DEF_SECTORS       = 16;
  localparam int DEF_COUNT_WIDTH   = 32;

  // sector index width that covers the largest sector count (64)
  localparam int SEC_IDX_W = 6;

  // full circle is 5760 = 128 * 45 in Q.4 degrees: drop 7 bits, then
  // divide by 45 through a reciprocal, exact for quotients below 224
  localparam int DIV_PRESHIFT = 7;
  localparam int RECIP_W      = 12;
  localparam int RECIP_MUL    = 2913;
  localparam int RECIP_SHIFT  = 17;

  // queue depth between front and back
  localparam int QUEUE_DEPTH = 4;

  // kind of work handed to the back end
  typedef enum logic [1:0] {
    OP_ADD,
    OP_READ,
    OP_REJECT
  } wrh_op_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } wrh_state_t;

  // one classified item in the queue
  typedef struct packed {
    wrh_op_t              op;
    logic                 hit;
    logic [CLS_W-1:0]     cls;
    logic [SEC_IDX_W-1:0] sec;
  } wrh_item_t;

endpackage

// ----- design/wind_rose_histogram.sv -----
// top level of the wind rose histogram
// Sorts anemometer samples into a histogram of speed classes by direction sectors
// (SPEED_CLASSES x SECTORS bins of COUNT_WIDTH-bit saturating counts) and answers
// single-bin reads; every transfer in gives exactly one result transfer out. The
// front end registers and classifies one item per cycle into a four-entry queue
// whenever the queue has room; the back end handles each item in two states,
// ST_IDLE to read the bin memory and ST_READ to write the updated count and load
// the result register, and takes no new item before it is done with the last,
// ST_READ waiting while the result register is full. A sample passes through the
// input register, the queue, the bin read and the result register, and waits in
// the queue while items ahead of it are handled. After reset the back end clears
// the bin memory one entry per cycle, all SPEED_CLASSES * SECTORS entries (96 at
// the defaults), and accepts no input until then; configuration writes are taken
// at any time with cfg_ready held high and should be made while the block is idle.
module wind_rose_histogram
  import wrh_pkg::*;
#(
  parameter int SPEED_CLASSES = DEF_SPEED_CLASSES,
  parameter int SECTORS       = DEF_SECTORS,
  parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LIMIT_W-1:0]    cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata: speed [15:0], direction [28:16], read_speed_class [31:29],
  //        read_sector [35:32], zero pad [39:36]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: cmd [0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata: speed_class [2:0], sector [6:3], count [38:7], zero pad [39]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // tuser: rejected [0]
  output logic                  out_tuser
);

  wrh_item_t push_item;
  wrh_item_t head_item;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  logic      clear_busy;

  // accept and classify
  wrh_front #(
    .SPEED_CLASSES (SPEED_CLASSES),
    .SECTORS       (SECTORS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .clear_busy (clear_busy),
    .q_push     (q_push),
    .q_item     (push_item),
    .q_full     (q_full)
  );

  // decoupling queue
  wrh_fifo #(
    .WIDTH ($bits(wrh_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head_data (head_item),
    .empty     (q_empty)
  );

  // bin update and results
  wrh_back #(
    .SPEED_CLASSES (SPEED_CLASSES),
    .SECTORS       (SECTORS),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (head_item),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- design/wrh_front.sv -----
// front end: config registers, input register and sample classification
module wrh_front
  import wrh_pkg::*;
#(
  parameter int SPEED_CLASSES = DEF_SPEED_CLASSES,
  parameter int SECTORS       = DEF_SECTORS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  input  logic                 clear_busy,
  output logic                 q_push,
  output wrh_item_t            q_item,
  input  logic                 q_full
);

  localparam int NUM_USED = SPEED_CLASSES - 1;
  localparam int PROD_W   = DIR_W + $clog2(SECTORS + 1);
  localparam int Y_W      = PROD_W - DIV_PRESHIFT;
  localparam int Q_W      = Y_W + RECIP_W;
  localparam int QS_W     = Q_W - RECIP_SHIFT;

  logic [LIMIT_W-1:0]   lim_r [NUM_LIMITS];
  logic                 s1_valid_r;
  wrh_op_t              s1_op_r;
  logic                 s1_hit_r;
  logic [CLS_W-1:0]     s1_cls_r;
  logic [SEC_W-1:0]     s1_rsec_r;
  logic [Y_W-1:0]       s1_y_r;

  logic                 in_xfer;
  logic [SPEED_W-1:0]   in_speed;
  logic [DIR_W-1:0]     in_dir;
  logic [CLS_W-1:0]     in_rcls;
  logic [SEC_W-1:0]     in_rsec;
  logic [CLS_W-1:0]     spd_cls;
  logic [PROD_W-1:0]    dir_prod;
  logic [Q_W-1:0]       recip_prod;
  logic [QS_W-1:0]      quot;
  logic [SEC_IDX_W-1:0] dir_sec;

  // payload fields
  assign in_speed = in_tdata[15:0];
  assign in_dir   = in_tdata[28:16];
  assign in_rcls  = in_tdata[31:29];
  assign in_rsec  = in_tdata[35:32];

  // config writes, index beyond the list is dropped
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_LIMITS; k++) lim_r[k] <= LIMIT_RESET[k];
    end else if (cfg_valid) begin
      for (int k = 0; k < NUM_LIMITS; k++) begin
        if (cfg_index == CFG_IDX_W'(k)) lim_r[k] <= cfg_data;
      end
    end
  end

  // speed class: first limit that the speed is below
  always_comb begin
    spd_cls = CLS_W'(SPEED_CLASSES - 1);
    for (int k = NUM_USED - 1; k >= 0; k--) begin
      if (in_speed[LIMIT_W-1:0] < lim_r[k]) spd_cls = CLS_W'(k);
    end
  end

  // direction scaled by sector count, low bits dropped
  assign dir_prod = PROD_W'(in_dir) * PROD_W'(SECTORS);

  // input register, one item held for classification
  assign q_push    = s1_valid_r && !q_full;
  assign in_tready = !clear_busy && (!s1_valid_r || !q_full);
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (q_push) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_rsec_r <= in_rsec;
      s1_y_r    <= dir_prod[PROD_W-1:DIV_PRESHIFT];
      if (in_tuser) begin
        s1_op_r  <= OP_READ;
        s1_cls_r <= in_rcls;
        s1_hit_r <= (int'(in_rcls) < SPEED_CLASSES) && (int'(in_rsec) < SECTORS);
      end else if (in_speed[SPEED_W-1]) begin
        s1_op_r  <= OP_REJECT;
        s1_cls_r <= '0;
        s1_hit_r <= 1'b0;
      end else begin
        s1_op_r  <= OP_ADD;
        s1_cls_r <= spd_cls;
        s1_hit_r <= 1'b1;
      end
    end
  end

  // divide by 45 through the reciprocal, saturate to the last sector
  assign recip_prod = Q_W'(s1_y_r) * Q_W'(RECIP_MUL);
  assign quot       = recip_prod[Q_W-1:RECIP_SHIFT];
  always_comb begin
    if (int'(quot) >= SECTORS) dir_sec = SEC_IDX_W'(SECTORS - 1);
    else                       dir_sec = SEC_IDX_W'(quot);
  end

  // queue entry
  always_comb begin
    q_item.op  = s1_op_r;
    q_item.hit = s1_hit_r;
    q_item.cls = s1_cls_r;
    if (s1_op_r == OP_READ) q_item.sec = SEC_IDX_W'(s1_rsec_r);
    else if (s1_op_r == OP_ADD) q_item.sec = dir_sec;
    else q_item.sec = '0;
  end

endmodule

// ----- design/wrh_fifo.sv -----
// small register queue between front and back end
module wrh_fifo
  import wrh_pkg::*;
#(
  parameter int WIDTH = $bits(wrh_item_t),
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] fill_r;
  logic             do_push;
  logic             do_pop;

  assign full      = (fill_r == CNT_W'(DEPTH));
  assign empty     = (fill_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) fill_r <= fill_r + 1'b1;
      else if (do_pop && !do_push) fill_r <= fill_r - 1'b1;
    end
  end

endmodule

// ----- design/wrh_back.sv -----
// back end: bin memory, clearing pass, read-modify-write and result register
`include "assert_macros.svh"

module wrh_back
  import wrh_pkg::*;
#(
  parameter int SPEED_CLASSES = DEF_SPEED_CLASSES,
  parameter int SECTORS       = DEF_SECTORS,
  parameter int COUNT_WIDTH   = DEF_COUNT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wrh_item_t             q_head,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  clear_busy,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  localparam int BINS  = SPEED_CLASSES * SECTORS;
  localparam int BIN_W = $clog2(BINS);

  logic [COUNT_WIDTH-1:0] mem [BINS];
  logic [COUNT_WIDTH-1:0] rd_data_r;

  wrh_state_t             state_r;
  wrh_state_t             state_nxt;
  logic [BIN_W-1:0]       clr_r;
  wrh_item_t              cur_r;
  logic                   out_valid_r;
  logic [CLS_W-1:0]       out_cls_r;
  logic [SEC_W-1:0]       out_sec_r;
  logic [OUT_COUNT_W-1:0] out_cnt_r;
  logic                   out_rej_r;

  logic                   clr_last;
  logic                   out_free;
  logic                   out_load;
  logic                   mem_we;
  logic                   mem_re;
  logic [BIN_W-1:0]       rd_addr;
  logic [BIN_W-1:0]       wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [BIN_W-1:0]       cur_bin;
  logic [COUNT_WIDTH-1:0] inc_cnt;
  logic [COUNT_WIDTH-1:0] res_cnt;
  logic [OUT_COUNT_W-1:0] rpt_cnt;

  assign clr_last = (clr_r == BIN_W'(BINS - 1));
  assign out_free = !out_valid_r || out_tready;

  // bin addresses, out of range reads go to entry zero and report zero
  always_comb begin
    if (q_head.hit) rd_addr = BIN_W'(int'(q_head.cls) * SECTORS + int'(q_head.sec));
    else            rd_addr = '0;
  end
  assign cur_bin = BIN_W'(int'(cur_r.cls) * SECTORS + int'(cur_r.sec));

  // saturating increment of the bin read
  assign inc_cnt = (&rd_data_r) ? rd_data_r : rd_data_r + 1'b1;

  always_comb begin
    if (!cur_r.hit)              res_cnt = '0;
    else if (cur_r.op == OP_ADD) res_cnt = inc_cnt;
    else                         res_cnt = rd_data_r;
  end

  // fit the count to the result field
  if (COUNT_WIDTH > OUT_COUNT_W) begin : g_sat
    assign rpt_cnt = (|res_cnt[COUNT_WIDTH-1:OUT_COUNT_W]) ? '1
                                                            : res_cnt[OUT_COUNT_W-1:0];
  end else begin : g_ext
    assign rpt_cnt = OUT_COUNT_W'(res_cnt);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (!q_empty) state_nxt = ST_READ;
      ST_READ:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    clear_busy = 1'b0;
    q_pop      = 1'b0;
    mem_re     = 1'b0;
    out_load   = 1'b0;
    mem_we     = 1'b0;
    wr_addr    = cur_bin;
    wr_data    = inc_cnt;
    unique case (state_r)
      ST_CLEAR: begin
        clear_busy = 1'b1;
        mem_we     = 1'b1;
        wr_addr    = clr_r;
        wr_data    = '0;
      end
      ST_IDLE: begin
        q_pop  = !q_empty;
        mem_re = !q_empty;
      end
      ST_READ: begin
        out_load = out_free;
        mem_we   = out_free && (cur_r.op == OP_ADD);
      end
      default: begin
        clear_busy = 1'b1;
      end
    endcase
  end

  // bin memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (mem_re) rd_data_r <= mem[rd_addr];
  end

  // state, clearing sweep and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // current item and result payload
  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_head;
    if (out_load) begin
      out_rej_r <= (cur_r.op == OP_REJECT);
      out_cls_r <= cur_r.cls;
      out_sec_r <= cur_r.sec[SEC_W-1:0];
      out_cnt_r <= rpt_cnt;
    end
  end

  // result port: speed_class [2:0], sector [6:3], count [38:7], zero pad
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_sec_r, out_cls_r};
  // tuser: rejected [0]
  assign out_tuser  = out_rej_r;

  `WRH_ASSERT(a_clear_quiet, clk, rst_n, (state_r == ST_CLEAR) |-> (!out_valid_r && !q_pop), "result or pop during clearing pass")
  `WRH_ASSERT(a_read_gap, clk, rst_n, mem_re |=> !mem_re, "bin read issued before previous update finished")
  `WRH_ASSERT(a_reject_zero, clk, rst_n, (out_tvalid && out_tuser) |-> (out_tdata == '0), "rejected sample reports nonzero fields")

endmodule
